// ===== hw/rtl/gblur3_pkg.sv =====
// Shared types and constants of the 3x3 grayscale blur core.
// No dependencies; imported by every module of the block.
package gblur3_pkg;

	localparam int unsigned FRAME_SIZE = 256;
	localparam int unsigned COL_W = $clog2(FRAME_SIZE);
	localparam int unsigned ROW_W = $clog2(FRAME_SIZE + 2);
	localparam int unsigned PIX_W = 8;

	// Largest weighted sum is 16 * 255, which fits in 12 bits.
	localparam int unsigned SUM_W = 12;

	// Division by nine: floor(sum / 9) == (sum * RECIP9) >> RECIP_SHIFT for every sum below 2**15.
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP9 = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
	localparam int unsigned PROD_W = SUM_W + RECIP_W;
	localparam int unsigned QUO_W = PROD_W - RECIP_SHIFT;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_SIZE - 1);
	localparam logic [ROW_W-1:0] ROW_BOT_LAST = ROW_W'(FRAME_SIZE - 1);
	localparam logic [ROW_W-1:0] ROW_BOT_WRAP = ROW_W'(FRAME_SIZE);
	localparam logic [ROW_W-1:0] ROW_END = ROW_W'(FRAME_SIZE + 1);

	localparam logic [2:0] KERNEL_W [3][3] = '{
		'{3'd1, 3'd2, 3'd1},
		'{3'd2, 3'd4, 3'd2},
		'{3'd1, 3'd2, 3'd1}
	};

	typedef enum logic {
		ACT_PIXEL = 1'b0,
		ACT_FLUSH = 1'b1
	} action_t;

	typedef struct packed {
		action_t action;
		logic [PIX_W-1:0] pixel;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred_pixel;
		logic frame_last;
	} blur_t;

	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] newer;
	} line_entry_t;

	// New right-hand column of the window, top row first.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} win_col_t;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic lft_ok;
		logic rgt_ok;
	} edge_mask_t;

endpackage

// ===== hw/rtl/gblur3_line_mem.sv =====
// Line buffer memory: both previous lines of a column in one entry.
// Depends on gblur3_pkg; one read and one write port, registered read data.
module gblur3_line_mem
	import gblur3_pkg::*;
(
	input  logic clk,
	input  logic rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output line_entry_t rd_data,
	input  logic wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  line_entry_t wr_data
);

	line_entry_t mem [FRAME_SIZE];
	line_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/gblur3_window.sv =====
// 3x3 neighborhood register and masked weighted sum.
// Depends on gblur3_pkg; the sum is registered as it leaves the window.
module gblur3_window
	import gblur3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  win_col_t col_in,
	input  edge_mask_t mask,
	output logic [SUM_W-1:0] sum_s2
);

	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] win_nxt [3][3];
	logic [SUM_W-1:0] sum_nxt;
	logic [SUM_W-1:0] sum_q;
	logic row_ok [3];
	logic col_ok [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_nxt[k][0] = win_q[k][1];
			win_nxt[k][1] = win_q[k][2];
		end
		win_nxt[0][2] = col_in.top;
		win_nxt[1][2] = col_in.mid;
		win_nxt[2][2] = col_in.bot;
	end

	always_comb begin
		row_ok[0] = mask.top_ok;
		row_ok[1] = 1'b1;
		row_ok[2] = mask.bot_ok;
		col_ok[0] = mask.lft_ok;
		col_ok[1] = 1'b1;
		col_ok[2] = mask.rgt_ok;
	end

	// Masked taps are selected away, so unwritten line entries never reach the sum.
	always_comb begin
		sum_nxt = '0;
		for (int k = 0; k < 3; k++) begin
			for (int m = 0; m < 3; m++) begin
				if (row_ok[k] && col_ok[m]) begin
					sum_nxt = sum_nxt + SUM_W'(KERNEL_W[k][m]) * SUM_W'(win_nxt[k][m]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int m = 0; m < 3; m++) begin
					win_q[k][m] <= '0;
				end
			end
		end else if (shift_en) begin
			win_q <= win_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			sum_q <= sum_nxt;
		end
	end

	assign sum_s2 = sum_q;

endmodule

// ===== hw/rtl/gblur3_div9.sv =====
// Divide-by-nine unit: reciprocal multiply, registered product, then shift and saturate.
// Depends on gblur3_pkg.
module gblur3_div9
	import gblur3_pkg::*;
(
	input  logic clk,
	input  logic load,
	input  logic [SUM_W-1:0] sum,
	output logic [PIX_W-1:0] quotient
);

	logic [PROD_W-1:0] product_s3;
	logic [QUO_W-1:0] quo_full;

	always_ff @(posedge clk) begin
		if (load) begin
			product_s3 <= PROD_W'(sum) * PROD_W'(RECIP9);
		end
	end

	assign quo_full = product_s3[PROD_W-1:RECIP_SHIFT];
	assign quotient = (quo_full > QUO_W'(PIX_MAX)) ? PIX_MAX : quo_full[PIX_W-1:0];

endmodule

// ===== hw/rtl/gaussian_blur_3x3_gray_core.sv =====
// 3x3 blur of a square grayscale frame (kernel 1-2-1/2-4-2/1-2-1, sum divided by nine,
// saturated at 255, neighbors outside the frame taken as zero). Pixels enter in raster
// order, one beat per clock when both sides flow; a result beat appears FRAME_SIZE+1 input
// beats after its pixel and then passes s1, s2, s3 and the output register, so FRAME_SIZE+1
// flush beats must follow the last pixel of a frame. The rate is set by the line memory, read
// at accept and written back when s1 fires; this keeps one beat per clock while both sides flow.
// Depends on gblur3_pkg, gblur3_line_mem, gblur3_window and gblur3_div9.
module gaussian_blur_3x3_gray_core
	import gblur3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_ready,
	input  pix_t pix,
	output logic blur_valid,
	input  logic blur_ready,
	output blur_t blur
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic accept;
	logic col_is0;
	logic emit;
	logic last;
	edge_mask_t mask;

	logic valid_s1;
	logic emit_s1;
	logic last_s1;
	edge_mask_t mask_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] val_s1;
	line_entry_t rd_data;

	logic valid_s2;
	logic last_s2;
	logic [SUM_W-1:0] sum_s2;
	logic valid_s3;
	logic last_s3;
	logic [PIX_W-1:0] quotient;
	logic out_valid_q;
	blur_t blur_q;

	logic rdy_out;
	logic rdy_s3;
	logic rdy_s2;
	logic rdy_s1;
	logic s1_fire;
	logic s2_fire;
	logic s3_fire;
	win_col_t col_in;
	line_entry_t wr_data;

	assign rdy_out = !out_valid_q || blur_ready;
	assign rdy_s3 = !valid_s3 || rdy_out;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign pix_ready = rdy_s1;
	assign accept = pix_valid && pix_ready;
	assign s1_fire = valid_s1 && rdy_s2;
	assign s2_fire = valid_s2 && rdy_s3;
	assign s3_fire = valid_s3 && rdy_out;

	// Position of the output pixel trails the input position by one row and one column.
	always_comb begin
		col_is0 = (col_q == '0);
		emit = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !col_is0);
		last = (row_q >= ROW_END);
		if (!col_is0) begin
			mask.top_ok = (row_q >= ROW_W'(2));
			mask.bot_ok = (row_q <= ROW_BOT_LAST);
			mask.lft_ok = (col_q >= COL_W'(2));
			mask.rgt_ok = 1'b1;
		end else begin
			mask.top_ok = (row_q >= ROW_W'(3));
			mask.bot_ok = (row_q <= ROW_BOT_WRAP);
			mask.lft_ok = 1'b1;
			mask.rgt_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == COL_LAST) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= accept;
			end
			if (rdy_s2) begin
				valid_s2 <= s1_fire && emit_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= s2_fire;
			end
			if (rdy_out) begin
				out_valid_q <= s3_fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit;
			last_s1 <= last;
			mask_s1 <= mask;
			col_s1 <= col_q;
			val_s1 <= (pix.action == ACT_FLUSH) ? '0 : pix.pixel;
		end
		if (s1_fire) begin
			last_s2 <= last_s1;
		end
		if (s2_fire) begin
			last_s3 <= last_s2;
		end
		if (s3_fire) begin
			blur_q.blurred_pixel <= quotient;
			blur_q.frame_last <= last_s3;
		end
	end

	// The same column comes back only FRAME_SIZE beats later, long after its write-back.
	assign wr_data.older = rd_data.newer;
	assign wr_data.newer = val_s1;

	gblur3_line_mem u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (wr_data)
	);

	assign col_in.top = rd_data.older;
	assign col_in.mid = rd_data.newer;
	assign col_in.bot = val_s1;

	gblur3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_fire),
		.col_in   (col_in),
		.mask     (mask_s1),
		.sum_s2   (sum_s2)
	);

	gblur3_div9 u_div9 (
		.clk      (clk),
		.load     (s2_fire),
		.sum      (sum_s2),
		.quotient (quotient)
	);

	assign blur_valid = out_valid_q;
	assign blur = blur_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_LAST)
		else $error("column counter beyond frame width");

	a_end_at_col0: assert property (@(posedge clk) disable iff (!arst_n)
		row_q == ROW_END |-> col_q == '0)
		else $error("drain end reached away from column zero");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after the last beat");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rdy_s2 |-> !pix_ready)
		else $error("beat accepted while the first stage is stalled");

endmodule

// ===== test/gblur3_checker.sv =====
// Checker for the 3x3 grayscale blur core: watches both channels, predicts every blurred beat
// from the accepted pixel beats and compares them in order. Depends on gblur3_pkg.
module gblur3_checker
	import gblur3_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pix_valid,
	input  logic  pix_ready,
	input  pix_t  pix,
	input  logic  blur_valid,
	input  logic  blur_ready,
	input  blur_t blur,
	output int    fail_count,
	output int    pending,
	output int    blurred_seen,
	output int    frames_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WEIGHT [3][3] = '{'{1, 2, 1}, '{2, 4, 2}, '{1, 2, 1}};
	localparam int unsigned DIVISOR = 9;
	localparam int REPORT_LIMIT = 10;

	logic [PIX_W-1:0] older_row [FRAME_SIZE];
	logic [PIX_W-1:0] newer_row [FRAME_SIZE];
	logic [PIX_W-1:0] win [3][3];
	logic [COL_W-1:0] col_pos;
	logic [ROW_W-1:0] row_pos;
	blur_t blurred_due [$];

	task automatic note_failure(input string msg);
		if (fail_count < REPORT_LIMIT) begin
			$display("%0t ns: %s", $time, msg);
		end
		fail_count++;
	endtask

	// Advances the line stores, the window and the position by one beat, and queues the
	// blurred pixel that this beat completes, if any.
	task automatic take_pixel_beat(input pix_t beat);
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] top_px;
		logic [PIX_W-1:0] mid_px;
		logic emit;
		logic last;
		logic [3:0] ok;
		int ctr_row;
		int ctr_col;
		int unsigned weighted;
		int unsigned quo;
		blur_t res;

		v = (beat.action == ACT_FLUSH) ? '0 : beat.pixel;
		top_px = older_row[col_pos];
		mid_px = newer_row[col_pos];
		older_row[col_pos] = mid_px;
		newer_row[col_pos] = v;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top_px;
		win[1][2] = mid_px;
		win[2][2] = v;

		emit = (row_pos >= 2) || (row_pos == 1 && col_pos != 0);
		last = (row_pos == ROW_END);

		// The window center trails the incoming beat by one column and one row.
		if (col_pos != 0) begin
			ctr_row = int'(row_pos) - 1;
			ctr_col = int'(col_pos) - 1;
		end else begin
			ctr_row = int'(row_pos) - 2;
			ctr_col = int'(FRAME_SIZE) - 1;
		end

		if (last) begin
			col_pos = '0;
			row_pos = '0;
		end else if (col_pos == COL_LAST) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end

		if (emit) begin
			// ok bits: top, bottom, left, right neighbors lie inside the frame.
			ok[3] = ctr_row >= 1;
			ok[2] = ctr_row + 1 < int'(FRAME_SIZE);
			ok[1] = ctr_col >= 1;
			ok[0] = ctr_col + 1 < int'(FRAME_SIZE);
			weighted = 0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if ((r == 0 && !ok[3]) || (r == 2 && !ok[2]) ||
						(c == 0 && !ok[1]) || (c == 2 && !ok[0])) begin
						continue;
					end
					weighted += WEIGHT[r][c] * win[r][c];
				end
			end
			quo = weighted / DIVISOR;
			if (quo > PIX_MAX) begin
				quo = PIX_MAX;
			end
			res.blurred_pixel = quo[PIX_W-1:0];
			res.frame_last = last;
			blurred_due.push_back(res);
		end
	endtask

	task automatic check_blurred_beat(input blur_t got);
		blur_t want;

		if (blurred_due.size() == 0) begin
			note_failure($sformatf("blurred beat %0d with none expected: pixel %0d last %0b",
				blurred_seen, got.blurred_pixel, got.frame_last));
		end else begin
			want = blurred_due.pop_front();
			if (got.blurred_pixel !== want.blurred_pixel || got.frame_last !== want.frame_last) begin
				note_failure($sformatf(
					"blurred beat %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
					blurred_seen, want.blurred_pixel, want.frame_last,
					got.blurred_pixel, got.frame_last));
			end
		end
		blurred_seen++;
		if (got.frame_last === 1'b1) begin
			frames_seen++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (older_row[k]) begin
				older_row[k] = '0;
				newer_row[k] = '0;
			end
			foreach (win[r, c]) begin
				win[r][c] = '0;
			end
			col_pos = '0;
			row_pos = '0;
			blurred_due.delete();
			fail_count = 0;
			blurred_seen = 0;
			frames_seen = 0;
		end else begin
			if (pix_valid && pix_ready) begin
				take_pixel_beat(pix);
			end
			if (blur_valid && blur_ready) begin
				check_blurred_beat(blur);
			end
		end
		pending = blurred_due.size();
	end

endmodule

// ===== test/tb.sv =====
// Top of the blur core testbench: clock, reset, pixel beats in and blurred beats out with
// random idling, and the verdict. Depends on gblur3_pkg, the core and gblur3_checker.
module tb
	import gblur3_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LIMIT = 200_000;
	localparam int HOLD_CYCLES = 1500;
	localparam int TAIL_CYCLES = 32;
	localparam int TOTAL_BEATS = 1800;
	localparam int FIRST_HOLD_AT = 300;
	localparam int SECOND_HOLD_AT = 1000;
	localparam int BAND_W = 32;
	localparam int OPENING_LEN = 16;

	// Opening of the first row: extremes, single-bit patterns and flush beats among pixels.
	localparam pix_t OPENING [OPENING_LEN] = '{
		'{ACT_PIXEL, 8'h00}, '{ACT_PIXEL, 8'hFF}, '{ACT_PIXEL, 8'hFF}, '{ACT_PIXEL, 8'hFF},
		'{ACT_FLUSH, 8'hFF}, '{ACT_PIXEL, 8'h55}, '{ACT_PIXEL, 8'hAA}, '{ACT_FLUSH, 8'h5A},
		'{ACT_PIXEL, 8'h01}, '{ACT_PIXEL, 8'h80}, '{ACT_PIXEL, 8'h7F}, '{ACT_PIXEL, 8'hFE},
		'{ACT_PIXEL, 8'h00}, '{ACT_FLUSH, 8'h00}, '{ACT_PIXEL, 8'hFF}, '{ACT_PIXEL, 8'h00}
	};

	typedef enum int {
		TEX_NOISE,
		TEX_WHITE,
		TEX_BLACK,
		TEX_BRIGHT,
		TEX_BINARY
	} texture_t;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_ready;
	pix_t pix;
	logic blur_valid;
	logic blur_ready;
	blur_t blur;

	int fail_count;
	int pending;
	int blurred_seen;
	int frames_seen;

	logic hold_off;
	bit tx_idle;
	bit rx_idle;
	int tx_beats;
	int pixel_sent;
	int flush_sent;
	int rx_wait;
	int rx_next;
	int rx_count;
	longint cycles;
	texture_t band_tex [FRAME_SIZE / BAND_W];

	gaussian_blur_3x3_gray_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.blur_valid(blur_valid),
		.blur_ready(blur_ready),
		.blur      (blur)
	);

	gblur3_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.blur_valid  (blur_valid),
		.blur_ready  (blur_ready),
		.blur        (blur),
		.fail_count  (fail_count),
		.pending     (pending),
		.blurred_seen(blurred_seen),
		.frames_seen (frames_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Timeout after %0d cycles with %0d blurred beats outstanding.", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] texture_pixel(input texture_t tex);
		case (tex)
			TEX_WHITE:  return PIX_MAX;
			TEX_BLACK:  return '0;
			TEX_BRIGHT: return PIX_W'($urandom_range(180, 255));
			TEX_BINARY: return ($urandom_range(0, 1) != 0) ? PIX_MAX : '0;
			default:    return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic draw_bands();
		int pick;

		foreach (band_tex[b]) begin
			pick = $urandom_range(0, 7);
			band_tex[b] = (pick > int'(TEX_BINARY)) ? TEX_NOISE : texture_t'(pick);
		end
	endtask

	task automatic send_beat(input action_t act, input logic [PIX_W-1:0] value);
		int gap;
		pix_t b;

		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		b.action = act;
		b.pixel = value;
		pix_valid <= 1'b1;
		pix <= b;
		@(posedge clk);
		while (!pix_ready) begin
			@(posedge clk);
		end
		if (act == ACT_FLUSH) begin
			flush_sent++;
		end else begin
			pixel_sent++;
		end
		tx_beats++;
		if (tx_beats % 200 == 0) begin
			tx_idle = $urandom_range(0, 9) < 3;
		end
	endtask

	// Frame positions first_pos onward, textured in vertical bands four rows tall so that
	// flat white patches saturate the result; a few flush beats stand in for zero pixels.
	task automatic send_frame_pixels(input int first_pos, input int count, input int flush_pct);
		int pos;

		for (int n = 0; n < count; n++) begin
			pos = first_pos + n;
			if (pos % (4 * FRAME_SIZE) == 0) begin
				draw_bands();
			end
			if ($urandom_range(0, 99) < flush_pct) begin
				send_beat(ACT_FLUSH, PIX_W'($urandom_range(0, 255)));
			end else begin
				send_beat(ACT_PIXEL, texture_pixel(band_tex[(pos % FRAME_SIZE) / BAND_W]));
			end
		end
	endtask

	// Receiver: while idling, draws a stall after every blurred beat, and stays low during a hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_ready <= 1'b0;
			rx_wait <= 0;
			rx_count = 0;
			rx_idle = 1'b1;
		end else begin
			rx_next = rx_wait;
			if (blur_valid && blur_ready) begin
				rx_count++;
				if (rx_count % 150 == 0) begin
					rx_idle = $urandom_range(0, 9) < 3;
				end
				rx_next = rx_idle ? $urandom_range(0, 10) : 0;
			end else if (rx_next > 0) begin
				rx_next--;
			end
			rx_wait <= rx_next;
			blur_ready <= !hold_off && rx_next == 0;
		end
	end

	// Two long output hold-offs while pixels keep coming, so that the core fills up and
	// pushes back on its input.
	initial begin
		hold_off = 1'b0;
		while (rx_count < FIRST_HOLD_AT) begin
			@(negedge clk);
		end
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
		while (rx_count < SECOND_HOLD_AT) begin
			@(negedge clk);
		end
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		tx_idle = 1'b1;
		tx_beats = 0;
		pixel_sent = 0;
		flush_sent = 0;
		cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		draw_bands();
		foreach (OPENING[k]) begin
			send_beat(OPENING[k].action, OPENING[k].pixel);
		end
		send_frame_pixels(OPENING_LEN, TOTAL_BEATS - OPENING_LEN, 3);
		pix_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d pixel and %0d flush beats over the first rows of a frame.",
			pixel_sent, flush_sent);
		$display("Checked %0d blurred beats under random idling and two %0d-cycle hold-offs.",
			blurred_seen, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (pending != 0) begin
				$display("%0d expected blurred beats never arrived.", pending);
			end
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/gblur3_pkg.sv
hw/rtl/gblur3_line_mem.sv
hw/rtl/gblur3_window.sv
hw/rtl/gblur3_div9.sv
hw/rtl/gaussian_blur_3x3_gray_core.sv
test/gblur3_checker.sv
test/tb.sv
